/* sv/smoke_value_to_opacity_byte_defines.svh */
// assertion macros shared by the checker
`ifndef SMOKE_VALUE_TO_OPACITY_BYTE_DEFINES_SVH
`define SMOKE_VALUE_TO_OPACITY_BYTE_DEFINES_SVH

// property checked only while out of reset
`define SVOB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("svob assertion failed");

// property checked on every edge, reset included
`define SVOB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("svob assertion failed");

`endif

/* sv/svob_pkg.sv */
package svob_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned CellW   = 24;
  localparam int unsigned ValW    = 31;
  localparam int unsigned ExpW    = 22;
  localparam int unsigned FracW   = 16;
  localparam int unsigned RemW    = 45;
  localparam int unsigned QuoW    = 21;
  localparam int unsigned MantW   = 33;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [1:0] {
    ModeSoot  = 2'd0,
    ModeFire  = 2'd1,
    ModeWater = 2'd2,
    ModeOff   = 2'd3
  } mode_e;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegMode = 1'b0;
  localparam logic [CfgIdxW-1:0] RegCell = 1'b1;

  localparam logic [CellW-1:0] CellReset   = 24'd65536;
  localparam logic [31:0]      KSoot       = 32'd47092093;
  localparam logic [32:0]      WaterOffset = 33'd197;
  localparam logic [ValW-1:0]  FireMax     = 31'd78643200;
  localparam logic [45:0]      SootCap     = 46'h2000_0000_0000;
  localparam logic [ExpW-1:0]  ExpSat      = 22'h20_0000;
  localparam logic [MantW-1:0] OneQ32      = 33'h1_0000_0000;
  localparam logic [24:0]      FireRecip   = 25'd873;
  localparam logic [14:0]      FireDiv     = 15'd75;

  // one classified item between front and back
  typedef struct packed {
    mode_e             mode;
    logic [ValW-1:0]   val;
    logic              last;
  } item_t;

  // integer square root, used at elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] arg);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = arg;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^-(2^-n) in Q0.32 by repeated square roots
  function automatic logic [31:0] pow_tab(input int unsigned n);
    logic [63:0] t;
    t = isqrt64(64'h8000_0000_0000_0000);
    for (int unsigned k = 2; k <= n; k++) begin
      t = isqrt64({t[31:0], 32'h0});
    end
    return t[31:0];
  endfunction

endpackage

/* sv/svob_front.sv */
module svob_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  svob_pkg::mode_e               mode_i,
  input  logic                          in_push_i,
  output logic                          in_full_o,
  input  logic [svob_pkg::SampleW-1:0]  sample_value_i,
  input  logic                          last_sample_i,
  output logic                          q_push_o,
  input  logic                          q_full_i,
  output svob_pkg::item_t               q_item_o
);

  logic            f_valid_q, f_valid_d;
  svob_pkg::item_t f_item_q, f_item_d;
  logic            accept;
  logic            pos;
  logic [32:0]     xd;
  logic [svob_pkg::ValW-1:0] soot_val, fire_val, water_val;

  assign in_full_o = f_valid_q && q_full_i;
  assign accept    = in_push_i && !in_full_o;
  assign q_push_o  = f_valid_q && !q_full_i;
  assign q_item_o  = f_item_q;

  // clamp the sample for each mode
  always_comb begin
    pos       = !sample_value_i[31] && (sample_value_i != '0);
    soot_val  = pos ? sample_value_i[30:0] : '0;
    fire_val  = (soot_val > svob_pkg::FireMax) ? svob_pkg::FireMax : soot_val;
    xd        = {sample_value_i[31], sample_value_i} - svob_pkg::WaterOffset;
    water_val = (!xd[32] && (xd != '0)) ? xd[30:0] : '0;
  end

  // classify by mode
  always_comb begin
    f_item_d.mode = mode_i;
    f_item_d.last = last_sample_i;
    unique case (mode_i)
      svob_pkg::ModeSoot:  f_item_d.val = soot_val;
      svob_pkg::ModeFire:  f_item_d.val = fire_val;
      svob_pkg::ModeWater: f_item_d.val = water_val;
      svob_pkg::ModeOff:   f_item_d.val = '0;
      default:             f_item_d.val = '0;
    endcase
  end

  assign f_valid_d = accept || (f_valid_q && q_full_i);

  // front register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_item_q <= f_item_d;
    end
  end

endmodule

/* sv/svob_fifo.sv */
module svob_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  svob_pkg::item_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output svob_pkg::item_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  svob_pkg::item_t   mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* sv/svob_back.sv */
module svob_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [svob_pkg::CellW-1:0]   cell_size_i,
  input  logic                         q_empty_i,
  input  svob_pkg::item_t              q_item_i,
  output logic                         q_pop_o,
  output logic                         out_empty_o,
  input  logic                         out_pop_i,
  output logic [svob_pkg::ByteW-1:0]   opacity_byte_o,
  output logic                         last_byte_o
);

  localparam int unsigned NDec = svob_pkg::FracW;
  localparam int unsigned NV   = 2 + svob_pkg::QuoW + 1 + NDec + 1;

  typedef struct packed {
    svob_pkg::mode_e               mode;
    logic                          last;
    logic [svob_pkg::ExpW-1:0]     e;
    logic                          sat;
    logic [svob_pkg::RemW-1:0]     rem;
    logic [svob_pkg::QuoW-1:0]     quo;
    logic [svob_pkg::ByteW-1:0]    fbyte;
  } div_t;

  typedef struct packed {
    svob_pkg::mode_e               mode;
    logic                          last;
    logic [svob_pkg::ExpW-1:0]     e;
    logic [svob_pkg::ByteW-1:0]    fbyte;
    logic [svob_pkg::MantW-1:0]    m;
  } dec_t;

  logic                 adv, take;
  logic [NV-1:0]        vld_q;
  logic                 out_valid_q;
  logic [svob_pkg::CellW-1:0] cs;

  assign adv         = !out_valid_q || out_pop_i;
  assign take        = adv && !q_empty_i;
  assign q_pop_o     = take;
  assign out_empty_o = !out_valid_q;
  assign cs          = (cell_size_i == '0) ? svob_pkg::CellW'(1) : cell_size_i;

  // valid shift line, all stages move together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[NV-2:0], take};
      out_valid_q <= vld_q[NV-1];
    end
  end

  // stage a: products on the sample
  svob_pkg::mode_e a_mode_q;
  logic            a_last_q;
  logic [45:0]     a_p_q;
  logic [35:0]     a_wn_q;
  logic [14:0]     a_fy_q;
  logic [54:0]     a_sp;
  logic [34:0]     a_fp;

  always_comb begin
    a_sp = {31'h0, cell_size_i} * {24'h0, q_item_i.val};
    a_fp = {4'h0, q_item_i.val} * 35'd254;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_mode_q <= q_item_i.mode;
      a_last_q <= q_item_i.last;
      a_p_q    <= (a_sp > 55'(svob_pkg::SootCap)) ? svob_pkg::SootCap : a_sp[45:0];
      a_wn_q   <= {5'h0, q_item_i.val} * 36'd20;
      a_fy_q   <= a_fp[34:20];
    end
  end

  // stage b: soot exponent, divider setup, fire estimate
  svob_pkg::mode_e             b_mode_q;
  logic                        b_last_q;
  logic [svob_pkg::ExpW-1:0]   b_e_q;
  logic                        b_sat_q;
  logic [svob_pkg::RemW-1:0]   b_rem_q;
  logic [14:0]                 b_fy_q;
  logic [7:0]                  b_fq_q;
  logic [61:0]                 b_sprod;
  logic [29:0]                 b_ef;
  logic [51:0]                 b_num;
  logic [44:0]                 b_den;
  logic [24:0]                 b_fprod;

  always_comb begin
    b_sprod = {32'h0, a_p_q[45:16]} * {30'h0, svob_pkg::KSoot};
    b_ef    = b_sprod[61:32];
    b_num   = {a_wn_q, 16'h0};
    b_den   = {cs, 21'h0};
    b_fprod = {10'h0, a_fy_q} * svob_pkg::FireRecip;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_mode_q <= a_mode_q;
      b_last_q <= a_last_q;
      b_e_q    <= (b_ef >= 30'(svob_pkg::ExpSat)) ? svob_pkg::ExpSat : b_ef[21:0];
      b_sat_q  <= (b_num >= 52'(b_den));
      b_rem_q  <= b_num[44:0];
      b_fy_q   <= a_fy_q;
      b_fq_q   <= b_fprod[23:16];
    end
  end

  // fire quotient correction at divider entry
  div_t        d_in;
  logic [14:0] f_r;

  always_comb begin
    f_r         = b_fy_q - (15'(b_fq_q) * svob_pkg::FireDiv);
    d_in.mode   = b_mode_q;
    d_in.last   = b_last_q;
    d_in.e      = b_e_q;
    d_in.sat    = b_sat_q;
    d_in.rem    = b_rem_q;
    d_in.quo    = '0;
    d_in.fbyte  = (f_r >= svob_pkg::FireDiv) ? b_fq_q + 1'b1 : b_fq_q;
  end

  // water divider, one quotient bit per stage
  div_t d_q [svob_pkg::QuoW];

  for (genvar k = 0; k < svob_pkg::QuoW; k++) begin : g_div
    localparam int unsigned Bit = svob_pkg::QuoW - 1 - k;
    div_t                      src, nxt;
    logic [svob_pkg::RemW-1:0] trial;
    if (k == 0) begin : g_first
      assign src = d_in;
    end else begin : g_next
      assign src = d_q[k-1];
    end
    always_comb begin
      trial = svob_pkg::RemW'(cs) << Bit;
      nxt   = src;
      if (src.rem >= trial) begin
        nxt.rem      = src.rem - trial;
        nxt.quo[Bit] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        d_q[k] <= nxt;
      end
    end
  end

  // merge stage: pick the exponent
  div_t d_last;
  dec_t e_in;
  assign d_last = d_q[svob_pkg::QuoW-1];

  always_comb begin
    e_in.mode  = d_last.mode;
    e_in.last  = d_last.last;
    e_in.fbyte = d_last.fbyte;
    e_in.m     = svob_pkg::OneQ32;
    if (d_last.mode == svob_pkg::ModeWater) begin
      e_in.e = d_last.sat ? svob_pkg::ExpSat : {1'b0, d_last.quo};
    end else begin
      e_in.e = d_last.e;
    end
  end

  dec_t e_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_q <= e_in;
    end
  end

  // fractional power, one table multiply per stage
  dec_t m_q [NDec];

  for (genvar j = 0; j < NDec; j++) begin : g_dec
    localparam logic [31:0] Tab = svob_pkg::pow_tab(j + 1);
    dec_t        src, nxt;
    logic [64:0] pr;
    if (j == 0) begin : g_first
      assign src = e_q;
    end else begin : g_next
      assign src = m_q[j-1];
    end
    always_comb begin
      pr  = {32'h0, src.m} * {33'h0, Tab};
      nxt = src;
      if (src.e[svob_pkg::FracW-1-j]) begin
        nxt.m = pr[64:32];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        m_q[j] <= nxt;
      end
    end
  end

  // integer part of the exponent as a right shift
  dec_t       s_q, s_in;
  logic [5:0] ip;

  always_comb begin
    s_in = m_q[NDec-1];
    ip   = s_in.e[svob_pkg::ExpW-1:svob_pkg::FracW];
    if (ip[5]) begin
      s_in.m = '0;
    end else begin
      s_in.m = m_q[NDec-1].m >> ip[4:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q <= s_in;
    end
  end

  // final byte and output register
  logic [32:0]               diff;
  logic [40:0]               bprod;
  logic [svob_pkg::ByteW-1:0] byte_d;
  logic [svob_pkg::ByteW-1:0] byte_q;
  logic                      last_q;

  always_comb begin
    diff  = svob_pkg::OneQ32 - s_q.m;
    bprod = {8'h0, diff} * 41'd254;
    unique case (s_q.mode)
      svob_pkg::ModeSoot:  byte_d = bprod[39:32];
      svob_pkg::ModeWater: byte_d = bprod[39:32];
      svob_pkg::ModeFire:  byte_d = s_q.fbyte;
      svob_pkg::ModeOff:   byte_d = '0;
      default:             byte_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      byte_q <= byte_d;
      last_q <= s_q.last;
    end
  end

  assign opacity_byte_o = byte_q;
  assign last_byte_o    = last_q;

endmodule

/* sv/smoke_value_to_opacity_byte.sv */
// Opacity quantizer for signed Q16.16 grid samples.
// Input side is a queue write port: a sample transfers on a rising edge
// with push high and full low. Result side is a queue read port: the
// oldest result sits on opacity_byte_o/last_byte_o while empty is low and
// transfers on a rising edge with pop high.
// The mode and cell size are written through cfg_we_i/cfg_idx_i/cfg_data_i
// (index 0 mode, index 1 cell size); the user must write them only while
// no item is in flight; the block itself does not enforce this. Throughput
// is one sample per cycle while the receiver does not stall. Samples pass
// through the 21-stage water divider and the 16 table-multiply power stages.
// A front register classifies samples into a small queue; the back
// pipeline advances as a whole whenever its output register is free or
// being popped. When the receiver stalls, the pipeline holds, the queue
// fills, and then full rises.
// Reset clears all valid state: empty high, full low, mode soot,
// cell size 1.0.
module smoke_value_to_opacity_byte #(
  parameter int unsigned QDepth = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [svob_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [svob_pkg::CellW-1:0]    cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic [svob_pkg::SampleW-1:0]  sample_value_i,
  input  logic                          last_sample_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [svob_pkg::ByteW-1:0]    opacity_byte_o,
  output logic                          last_byte_o
);

  svob_pkg::mode_e            mode_q;
  logic [svob_pkg::CellW-1:0] cell_q;
  logic                       q_push, q_full, q_empty, q_pop;
  svob_pkg::item_t            q_wdata, q_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= svob_pkg::ModeSoot;
      cell_q <= svob_pkg::CellReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        svob_pkg::RegMode: mode_q <= svob_pkg::mode_e'(cfg_data_i[1:0]);
        svob_pkg::RegCell: cell_q <= cfg_data_i;
        default:           cell_q <= cell_q;
      endcase
    end
  end

  svob_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (mode_q),
    .in_push_i      (push),
    .in_full_o      (full),
    .sample_value_i (sample_value_i),
    .last_sample_i  (last_sample_i),
    .q_push_o       (q_push),
    .q_full_i       (q_full),
    .q_item_o       (q_wdata)
  );

  svob_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  svob_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cell_size_i    (cell_q),
    .q_empty_i      (q_empty),
    .q_item_i       (q_rdata),
    .q_pop_o        (q_pop),
    .out_empty_o    (empty),
    .out_pop_i      (pop),
    .opacity_byte_o (opacity_byte_o),
    .last_byte_o    (last_byte_o)
  );

endmodule

/* sv/svob_checker.sv */
`include "smoke_value_to_opacity_byte_defines.svh"

module svob_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          push,
  input logic                          full,
  input logic                          empty,
  input logic                          pop,
  input logic [svob_pkg::ByteW-1:0]    opacity_byte_o,
  input logic                          last_byte_o
);

  // a waiting result holds until its transfer
  `SVOB_ASSERT(a_hold, !empty && !pop |=> !empty && $stable(opacity_byte_o) && $stable(last_byte_o))

  // opacity never exceeds 254
  `SVOB_ASSERT(a_range, !empty |-> opacity_byte_o != 8'hFF)

  // nothing waits and nothing blocks right after reset
  `SVOB_ASSERT_ALWAYS(a_reset, $rose(rst_ni) |-> empty && !full)

  // a waiting result carries known fields
  `SVOB_ASSERT(a_known, !empty |-> !$isunknown({opacity_byte_o, last_byte_o}))

endmodule

bind smoke_value_to_opacity_byte svob_checker u_svob_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .push           (push),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .opacity_byte_o (opacity_byte_o),
  .last_byte_o    (last_byte_o)
);
